[rtl/dns_query_name_encoder_top_assert.svh]
// Assertion macros for the DNS question-name encoder checker.
`ifndef DNS_QUERY_NAME_ENCODER_TOP_ASSERT_SVH
`define DNS_QUERY_NAME_ENCODER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while in reset.
`define DQE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DQE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/dqe_pkg.sv]
// Shared types and constants of the DNS question-name encoder.
package dqe_pkg;

  localparam int OFF_W    = 9;
  localparam int SUM_W    = 11;
  localparam int TOTAL_W  = 10;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [OFF_W-1:0] MAX_LABEL = 9'd63;
  localparam logic [OFF_W-1:0] COUNT_SAT = 9'd511;
  localparam logic [7:0]       DOT_CHAR  = 8'd46;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_QTYPE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QCLASS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 2'd2;

  localparam logic [CFG_W-1:0] QTYPE_RST  = 16'd1;
  localparam logic [CFG_W-1:0] QCLASS_RST = 16'd1;
  localparam logic [OFF_W-1:0] LIMIT_RST  = 9'd507;

  // job queue
  localparam int JOB_DEPTH = 4;
  localparam int JOB_PTR_W = $clog2(JOB_DEPTH);
  localparam int JOB_CNT_W = $clog2(JOB_DEPTH + 1);

  // One classified item, handed from front to back.
  typedef struct packed {
    logic               is_end;   // end-of-name run, else one plain word
    logic               has_len;  // end run: last label non-empty
    logic               err;      // sticky error after this item
    logic [OFF_W-1:0]   off;      // word offset / label start
    logic [7:0]         data;     // character or label length
    logic [OFF_W-1:0]   term;     // terminator offset
    logic [OFF_W-1:0]   end_pos;  // first byte after terminator
    logic [TOTAL_W-1:0] total;    // question length, zero on error
  } job_t;

  typedef enum logic [5:0] {
    ST_LEN      = 6'b000001,
    ST_TERM     = 6'b000010,
    ST_TYPE_HI  = 6'b000100,
    ST_TYPE_LO  = 6'b001000,
    ST_CLASS_HI = 6'b010000,
    ST_CLASS_LO = 6'b100000
  } step_e;

endpackage

[rtl/dqe_front.sv]
// Front end: takes name items, tracks label state, builds jobs.
module dqe_front import dqe_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic             kind_i,
  input  logic [7:0]       ch_i,
  input  logic [OFF_W-1:0] size_limit_i,
  input  logic             q_full_i,
  output logic             q_push_o,
  output job_t             q_job_o
);

  logic [OFF_W-1:0] label_start_q, label_start_d;
  logic [OFF_W-1:0] label_count_q, label_count_d;
  logic             failed_q, failed_d;

  logic             accept;
  logic [OFF_W-1:0] count_inc;
  logic [SUM_W-1:0] limit_w, next_pos, inc_end, term, end_pos, total_w;
  logic             has_len, fail_now, failed_new;

  assign accept   = push_i && !q_full_i;
  assign q_push_o = accept;

  always_comb begin
    limit_w   = {2'b00, size_limit_i};
    count_inc = (label_count_q == COUNT_SAT) ? label_count_q : label_count_q + 9'd1;
    next_pos  = {2'b00, label_start_q} + 11'd1 + {2'b00, label_count_q};
    inc_end   = {2'b00, label_start_q} + 11'd1 + {2'b00, count_inc};
    has_len   = (label_count_q != '0);
    term      = has_len ? next_pos : {2'b00, label_start_q};
    end_pos   = term + 11'd1;

    fail_now = 1'b0;
    if (kind_i) begin
      fail_now = (has_len && (label_count_q > MAX_LABEL)) || (end_pos > limit_w);
    end else if (ch_i == DOT_CHAR) begin
      fail_now = (label_count_q > MAX_LABEL) || (next_pos > limit_w);
    end else begin
      fail_now = (count_inc > MAX_LABEL) || (inc_end > limit_w);
    end
    failed_new = failed_q || fail_now;
    total_w    = failed_new ? '0 : end_pos + 11'd4;

    q_job_o.is_end  = kind_i;
    q_job_o.has_len = has_len;
    q_job_o.err     = failed_new;
    q_job_o.term    = term[OFF_W-1:0];
    q_job_o.end_pos = end_pos[OFF_W-1:0];
    q_job_o.total   = total_w[TOTAL_W-1:0];
    if (kind_i || (ch_i == DOT_CHAR)) begin
      q_job_o.off  = label_start_q;
      q_job_o.data = label_count_q[7:0];
    end else begin
      q_job_o.off  = next_pos[OFF_W-1:0];
      q_job_o.data = ch_i;
    end

    label_start_d = label_start_q;
    label_count_d = label_count_q;
    failed_d      = failed_q;
    if (accept) begin
      if (kind_i) begin
        label_start_d = '0;
        label_count_d = '0;
        failed_d      = 1'b0;
      end else if (ch_i == DOT_CHAR) begin
        label_start_d = next_pos[OFF_W-1:0];
        label_count_d = '0;
        failed_d      = failed_new;
      end else begin
        label_count_d = count_inc;
        failed_d      = failed_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      label_start_q <= '0;
      label_count_q <= '0;
      failed_q      <= 1'b0;
    end else begin
      label_start_q <= label_start_d;
      label_count_q <= label_count_d;
      failed_q      <= failed_d;
    end
  end

endmodule

[rtl/dqe_job_fifo.sv]
// Short job queue between front and back.
module dqe_job_fifo import dqe_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t job_o
);

  job_t                 mem_q [JOB_DEPTH];
  logic [JOB_PTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [JOB_CNT_W-1:0] cnt_q, cnt_d;
  logic                 do_pop;

  assign full_o  = (cnt_q == JOB_CNT_W'(JOB_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rptr_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d = push_i ? wptr_q + 1'b1 : wptr_q;
    rptr_d = do_pop ? rptr_q + 1'b1 : rptr_q;
    cnt_d  = cnt_q;
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

[rtl/dqe_back.sv]
// Back end: expands jobs into byte writes and drives the output register.
module dqe_back import dqe_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               job_valid_i,
  input  job_t               job_i,
  output logic               job_pop_o,
  input  logic [CFG_W-1:0]   query_type_i,
  input  logic [CFG_W-1:0]   query_class_i,
  output logic               empty_o,
  input  logic               pop_i,
  output logic [OFF_W-1:0]   out_offset_o,
  output logic [7:0]         out_byte_o,
  output logic               out_last_o,
  output logic               error_o,
  output logic [TOTAL_W-1:0] total_length_o
);

  step_e step_q, step_d, cur, nxt;

  logic               out_valid_q, out_valid_d;
  logic [OFF_W-1:0]   off_q, off_d;
  logic [7:0]         byte_q, byte_d;
  logic               last_q, last_d;
  logic               err_q;
  logic [TOTAL_W-1:0] total_q, total_d;

  logic adv, done;

  // a job is waiting and the output slot is free or being drained this cycle
  assign adv = job_valid_i && (!out_valid_q || pop_i);

  always_comb begin
    cur = (step_q == ST_LEN && !job_i.has_len) ? ST_TERM : step_q;
    off_d   = job_i.off;
    byte_d  = job_i.data;
    last_d  = 1'b0;
    total_d = '0;
    nxt     = ST_LEN;
    if (job_i.is_end) begin
      unique case (cur)
        ST_LEN: begin
          nxt = ST_TERM;
        end
        ST_TERM: begin
          off_d  = job_i.term;
          byte_d = '0;
          nxt    = ST_TYPE_HI;
        end
        ST_TYPE_HI: begin
          off_d  = job_i.end_pos;
          byte_d = query_type_i[15:8];
          nxt    = ST_TYPE_LO;
        end
        ST_TYPE_LO: begin
          off_d  = job_i.end_pos + 9'd1;
          byte_d = query_type_i[7:0];
          nxt    = ST_CLASS_HI;
        end
        ST_CLASS_HI: begin
          off_d  = job_i.end_pos + 9'd2;
          byte_d = query_class_i[15:8];
          nxt    = ST_CLASS_LO;
        end
        ST_CLASS_LO: begin
          off_d   = job_i.end_pos + 9'd3;
          byte_d  = query_class_i[7:0];
          last_d  = 1'b1;
          total_d = job_i.total;
          nxt     = ST_LEN;
        end
        default: begin
          nxt = ST_LEN;
        end
      endcase
    end
    done      = !job_i.is_end || (cur == ST_CLASS_LO);
    job_pop_o = adv && done;

    step_d = step_q;
    if (adv) begin
      step_d = done ? ST_LEN : nxt;
    end

    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= ST_LEN;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      off_q   <= off_d;
      byte_q  <= byte_d;
      last_q  <= last_d;
      err_q   <= job_i.err;
      total_q <= total_d;
    end
  end

  assign empty_o        = !out_valid_q;
  assign out_offset_o   = off_q;
  assign out_byte_o     = byte_q;
  assign out_last_o     = last_q;
  assign error_o        = err_q;
  assign total_length_o = total_q;

endmodule

[rtl/dns_query_name_encoder_top.sv]
// Top level of the DNS question-name encoder.
//
// Input side is a queue: present kind_i/ch_i with push, the word is taken on a
// clock edge where push is high and full is low. kind_i=0 carries one host
// name character (a dot closes a label), kind_i=1 ends the name.
// Output side is a queue too: while empty is low the oldest byte write sits on
// out_offset_o/out_byte_o with out_last_o, error_o and total_length_o; pop
// takes it. A character or dot gives one word, an end item gives five or six
// (length byte if the last label is non-empty, terminator, type, class).
// An accepted word passes through the job queue and then the output register.
// Throughput: one input word per cycle while full is low; one output word per
// cycle while pop keeps up, so an end item holds the back end for five or six
// words while the job queue (4 deep) absorbs input. full rises only when it fills.
// If the receiver stalls, the output register holds its word, the back end
// stops, the queue fills and full goes high; nothing is dropped.
// Reset (rst_ni low, async) clears label state, queue and the output valid flag;
// query type/class reset to 1 and the size limit to 507.
// Config writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) are registered and are
// meant for idle periods only; index 3 is ignored.
module dns_query_name_encoder_top import dqe_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 push,
  output logic                 full,
  input  logic                 kind_i,
  input  logic [7:0]           ch_i,
  output logic                 empty,
  input  logic                 pop,
  output logic [OFF_W-1:0]     out_offset_o,
  output logic [7:0]           out_byte_o,
  output logic                 out_last_o,
  output logic                 error_o,
  output logic [TOTAL_W-1:0]   total_length_o
);

  // config registers
  logic [CFG_W-1:0] query_type_q, query_class_q;
  logic [OFF_W-1:0] size_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      query_type_q  <= QTYPE_RST;
      query_class_q <= QCLASS_RST;
      size_limit_q  <= LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_QTYPE:  query_type_q  <= cfg_wdata_i;
        REG_QCLASS: query_class_q <= cfg_wdata_i;
        REG_LIMIT:  size_limit_q  <= cfg_wdata_i[OFF_W-1:0];
        default: ;  // unmapped index
      endcase
    end
  end

  logic q_push, q_full, q_valid, q_pop;
  job_t q_wjob, q_rjob;

  assign full = q_full;

  // front: label bookkeeping and error checks
  dqe_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .kind_i      (kind_i),
    .ch_i        (ch_i),
    .size_limit_i(size_limit_q),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_job_o     (q_wjob)
  );

  // decouples the single-word front from the multi-word end runs
  dqe_job_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .job_i  (q_wjob),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .job_o  (q_rjob)
  );

  // back: one byte write per cycle into the output register while the receiver keeps popping
  dqe_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_valid_i   (q_valid),
    .job_i         (q_rjob),
    .job_pop_o     (q_pop),
    .query_type_i  (query_type_q),
    .query_class_i (query_class_q),
    .empty_o       (empty),
    .pop_i         (pop),
    .out_offset_o  (out_offset_o),
    .out_byte_o    (out_byte_o),
    .out_last_o    (out_last_o),
    .error_o       (error_o),
    .total_length_o(total_length_o)
  );

endmodule

[rtl/dqe_checker.sv]
// Port-level checker for the DNS question-name encoder, bound to the top.
`include "dns_query_name_encoder_top_assert.svh"

module dqe_checker import dqe_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 empty,
  input logic                 pop,
  input logic [OFF_W-1:0]     out_offset_o,
  input logic [7:0]           out_byte_o,
  input logic                 out_last_o,
  input logic                 error_o,
  input logic [TOTAL_W-1:0]   total_length_o
);

  // a stalled word stays put
  `DQE_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(out_offset_o) && $stable(out_byte_o), "output word changed while stalled")

  // length only on a clean final word
  `DQE_ASSERT_NOW(a_total_only_last, !empty && (total_length_o != '0), out_last_o && !error_o, "total length outside clean last word")

  // length is one past the class low byte
  `DQE_ASSERT_NOW(a_total_offset, !empty && out_last_o && !error_o, total_length_o[OFF_W-1:0] == (out_offset_o + 9'd1), "total length does not match final offset")

  // error stays set until the name closes
  `DQE_ASSERT_NEXT(a_err_sticky, !empty && pop && !out_last_o && error_o, empty || error_o, "error flag dropped inside a name")

endmodule

bind dns_query_name_encoder_top dqe_checker u_dqe_checker (.*);
